[rtl/tes_pkg.sv]
`timescale 1ns / 1ps

package tes_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int NODE_BITS  = 10;
    localparam int K_BITS     = 32;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int MAG_W  = NUM_W - 1;
    localparam int DET_W  = PROD_W + 1;
    localparam int DEN_W  = DET_W;
    // quotient bits below the sign, integer part plus fraction
    localparam int QBITS  = K_BITS - 1;
    localparam int LOW_W  = QBITS - FRAC_BITS;
    localparam int HIGH_W = MAG_W - LOW_W;
    localparam int N_ENT  = 6;

    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 224;

    typedef struct packed {
        logic [NODE_BITS-1:0] node_a;
        logic [NODE_BITS-1:0] node_b;
        logic [NODE_BITS-1:0] node_c;
        logic                 fin;
    } tag_t;

    typedef struct packed {
        tag_t              tag;
        logic              degen;
        logic [N_ENT-1:0]  neg;
        logic [N_ENT-1:0]  sat;
    } meta_t;

endpackage

[rtl/triangle_element_stiffness_top.sv]
`timescale 1ns / 1ps

// linear triangle element stiffness: takes one triangle beat per cycle and returns
// the six unique entries of the symmetric 3x3 laplace matrix in signed q15.16,
// truncated toward zero and saturated; a zero-area triangle gives zeros and
// sets tuser. throughput is one beat per clock unless the output stalls. the
// pipeline has five arithmetic stages (differences, products, sums, abs, saturation check),
// 31 restoring divider stages working on all six entries in parallel, and an
// output register. the whole pipeline holds while a result waits on m_tready.
module triangle_element_stiffness_top
    import tes_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // ax, ay, bx, by_coord, cx, cy, node_a, node_b, node_c, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // k_aa, k_bb, k_cc, k_ab, k_bc, k_ca, out_node_a, out_node_b, out_node_c, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    // degenerate
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic en;

    logic signed [COORD_BITS-1:0] xin [3];
    logic signed [COORD_BITS-1:0] yin [3];
    tag_t tag_in;

    // stage 1
    logic v1_reg;
    tag_t tag1_reg;
    logic signed [DIFF_W-1:0] dx_reg [3];
    logic signed [DIFF_W-1:0] dy_reg [3];
    // stage 2
    logic v2_reg;
    tag_t tag2_reg;
    logic signed [PROD_W-1:0] py_reg [N_ENT];
    logic signed [PROD_W-1:0] px_reg [N_ENT];
    logic signed [PROD_W-1:0] m1_reg;
    logic signed [PROD_W-1:0] m2_reg;
    // stage 3
    logic v3_reg;
    tag_t tag3_reg;
    logic signed [NUM_W-1:0] num_reg [N_ENT];
    logic signed [DET_W-1:0] det_reg;
    // stage 4
    logic v4_reg;
    tag_t tag4_reg;
    logic [N_ENT-1:0] neg4_reg;
    logic degen4_reg;
    logic [MAG_W-1:0] mag_reg [N_ENT];
    logic [DEN_W-1:0] den4_reg;
    // divider stages, index 0 is the saturation check stage
    logic             dv_reg  [QBITS+1];
    meta_t            meta_reg [QBITS+1];
    logic [DEN_W-1:0] den_reg [QBITS+1];
    logic [DEN_W-1:0] r_reg   [QBITS+1][N_ENT];
    logic [QBITS-1:0] q_reg   [QBITS+1][N_ENT];
    logic [LOW_W-1:0] lo_reg  [QBITS+1][N_ENT];
    logic [DEN_W:0]   trial   [QBITS][N_ENT];
    logic             take    [QBITS][N_ENT];
    // output
    logic             ov_reg;
    logic [K_BITS-1:0] k_reg [N_ENT];
    tag_t             tago_reg;
    logic             degeno_reg;

    logic [K_BITS-1:0] k_next [N_ENT];

    localparam int PI [N_ENT] = '{0, 1, 2, 0, 1, 2};
    localparam int PJ [N_ENT] = '{0, 1, 2, 1, 2, 0};

    assign en       = !ov_reg || m_tready;
    assign s_tready = en;

    assign xin[0] = s_tdata[15:0];
    assign yin[0] = s_tdata[31:16];
    assign xin[1] = s_tdata[47:32];
    assign yin[1] = s_tdata[63:48];
    assign xin[2] = s_tdata[79:64];
    assign yin[2] = s_tdata[95:80];
    assign tag_in.node_a = s_tdata[105:96];
    assign tag_in.node_b = s_tdata[115:106];
    assign tag_in.node_c = s_tdata[125:116];
    assign tag_in.fin    = s_tlast;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            for (int s = 0; s <= QBITS; s++)
            begin
                dv_reg[s] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            dv_reg[0] <= v4_reg;
            for (int s = 0; s < QBITS; s++)
            begin
                dv_reg[s+1] <= dv_reg[s];
            end
            ov_reg <= dv_reg[QBITS];
        end
    end

    // arithmetic front end
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag1_reg <= tag_in;
            for (int i = 0; i < 3; i++)
            begin
                dx_reg[i] <= DIFF_W'(xin[(i+1)%3]) - DIFF_W'(xin[(i+2)%3]);
                dy_reg[i] <= DIFF_W'(yin[(i+1)%3]) - DIFF_W'(yin[(i+2)%3]);
            end

            tag2_reg <= tag1_reg;
            for (int i = 0; i < N_ENT; i++)
            begin
                py_reg[i] <= PROD_W'(dy_reg[PI[i]] * dy_reg[PJ[i]]);
                px_reg[i] <= PROD_W'(dx_reg[PI[i]] * dx_reg[PJ[i]]);
            end
            // det = dx1*dy2 - dx2*dy1
            m1_reg <= PROD_W'(dx_reg[1] * dy_reg[2]);
            m2_reg <= PROD_W'(dx_reg[2] * dy_reg[1]);

            tag3_reg <= tag2_reg;
            for (int i = 0; i < N_ENT; i++)
            begin
                num_reg[i] <= NUM_W'(py_reg[i]) + NUM_W'(px_reg[i]);
            end
            det_reg <= DET_W'(m1_reg) - DET_W'(m2_reg);

            tag4_reg   <= tag3_reg;
            degen4_reg <= (det_reg == '0);
            for (int i = 0; i < N_ENT; i++)
            begin
                neg4_reg[i] <= num_reg[i][NUM_W-1];
                mag_reg[i]  <= num_reg[i][NUM_W-1] ? MAG_W'(-num_reg[i])
                                                   : MAG_W'(num_reg[i]);
            end
            // twice the absolute determinant
            den4_reg <= det_reg[DET_W-1] ? DEN_W'((-det_reg) <<< 1)
                                         : DEN_W'(det_reg <<< 1);
        end
    end

    // restoring divider, one quotient bit per stage
    always_comb
    begin
        for (int s = 0; s < QBITS; s++)
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                trial[s][i] = {r_reg[s][i], lo_reg[s][i][LOW_W-1]};
                take[s][i]  = (trial[s][i] >= {1'b0, den_reg[s]});
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // saturation check and divider seed
            meta_reg[0].tag   <= tag4_reg;
            meta_reg[0].degen <= degen4_reg;
            meta_reg[0].neg   <= neg4_reg;
            den_reg[0]        <= den4_reg;
            for (int i = 0; i < N_ENT; i++)
            begin
                meta_reg[0].sat[i] <= (DEN_W'(mag_reg[i][MAG_W-1:LOW_W]) >= den4_reg);
                r_reg[0][i]  <= DEN_W'(mag_reg[i][MAG_W-1:LOW_W]);
                q_reg[0][i]  <= '0;
                lo_reg[0][i] <= mag_reg[i][LOW_W-1:0];
            end

            for (int s = 0; s < QBITS; s++)
            begin
                meta_reg[s+1] <= meta_reg[s];
                den_reg[s+1]  <= den_reg[s];
                for (int i = 0; i < N_ENT; i++)
                begin
                    r_reg[s+1][i]  <= take[s][i]
                                      ? DEN_W'(trial[s][i] - {1'b0, den_reg[s]})
                                      : DEN_W'(trial[s][i]);
                    q_reg[s+1][i]  <= {q_reg[s][i][QBITS-2:0], take[s][i]};
                    lo_reg[s+1][i] <= {lo_reg[s][i][LOW_W-2:0], 1'b0};
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < N_ENT; i++)
        begin
            if (meta_reg[QBITS].degen)
            begin
                k_next[i] = '0;
            end
            else if (meta_reg[QBITS].sat[i])
            begin
                k_next[i] = meta_reg[QBITS].neg[i] ? {1'b1, {QBITS{1'b0}}}
                                                   : {1'b0, {QBITS{1'b1}}};
            end
            else if (meta_reg[QBITS].neg[i])
            begin
                k_next[i] = K_BITS'(-{1'b0, q_reg[QBITS][i]});
            end
            else
            begin
                k_next[i] = {1'b0, q_reg[QBITS][i]};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N_ENT; i++)
            begin
                k_reg[i] <= k_next[i];
            end
            tago_reg   <= meta_reg[QBITS].tag;
            degeno_reg <= meta_reg[QBITS].degen;
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {2'b00, tago_reg.node_c, tago_reg.node_b, tago_reg.node_a,
                       k_reg[5], k_reg[4], k_reg[3], k_reg[2], k_reg[1], k_reg[0]};
    assign m_tuser  = degeno_reg;
    assign m_tlast  = tago_reg.fin;

`ifndef SYNTH
    // a degenerate triangle gives all-zero entries
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[191:0] == '0))
        else $error("degenerate result with nonzero entries");

    // diagonal entries come from sums of squares
    a_diag_nonneg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[31] && !m_tdata[63] && !m_tdata[95]))
        else $error("negative diagonal entry");

    // an accepted beat enters the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted beat lost at pipeline entry");
`endif

endmodule

[tb/tb_triangle_element_stiffness_top.sv]
`timescale 1ns / 1ps

module tb_triangle_element_stiffness_top;
    import tes_pkg::*;

    typedef struct packed {
        logic signed [15:0] ax, ay, bx, by_coord, cx, cy;
        logic [9:0] node_a, node_b, node_c;
        logic       fin;
    } tri_t;

    typedef struct packed {
        logic [5:0][31:0] k;
        logic [9:0]  na, nb, nc;
        logic        degen;
        logic        fin;
    } kmat_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [IN_DATA_W-1:0] s_tdata;
    logic s_tlast;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic m_tuser;
    logic m_tlast;

    tri_t  pending_tris[$];
    kmat_t expected_mats[$];
    int    send_idle_pct;
    int    recv_stall_pct;
    int    mismatches;
    int    results_seen;
    int    degen_seen;
    int    sat_seen;
    bit    in_taken;

    triangle_element_stiffness_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // num / den, Q15.16, truncated toward zero and saturated
    function automatic logic [31:0] q16_ratio(longint num, longint unsigned den);
        logic                neg;
        longint unsigned     mag;
        longint unsigned     q;
        longint unsigned     r;
        longint unsigned     res;
        neg = num < 0;
        mag = neg ? -num : num;
        q = mag / den;
        r = mag % den;
        if (q >= (64'd1 << 15))
            return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        res = q;
        for (int b = 0; b < 16; b++)
        begin
            r = r << 1;
            res = res << 1;
            if (r >= den)
            begin
                r = r - den;
                res = res | 1;
            end
        end
        if (neg)
            res = -res;
        return res[31:0];
    endfunction

    function automatic kmat_t element_stiffness(tri_t t);
        kmat_t m;
        longint x[3];
        longint y[3];
        longint dx[3];
        longint dy[3];
        longint det;
        longint unsigned den;
        int ei[6];
        int ej[6];
        ei = '{0, 1, 2, 0, 1, 2};
        ej = '{0, 1, 2, 1, 2, 0};
        x[0] = t.ax; y[0] = t.ay;
        x[1] = t.bx; y[1] = t.by_coord;
        x[2] = t.cx; y[2] = t.cy;
        for (int i = 0; i < 3; i++)
        begin
            dy[i] = y[(i + 1) % 3] - y[(i + 2) % 3];
            dx[i] = x[(i + 1) % 3] - x[(i + 2) % 3];
        end
        det = (x[1] - x[0]) * (y[2] - y[0]) - (x[2] - x[0]) * (y[1] - y[0]);
        m.degen = (det == 0);
        den = (det < 0 ? -det : det) * 2;
        for (int i = 0; i < 6; i++)
            m.k[i] = m.degen ? 32'd0
                : q16_ratio(dy[ei[i]] * dy[ej[i]] + dx[ei[i]] * dx[ej[i]], den);
        m.na = t.node_a;
        m.nb = t.node_b;
        m.nc = t.node_c;
        m.fin = t.fin;
        return m;
    endfunction

    function automatic logic signed [15:0] rand_coord(int span);
        if (span == 0)
            return $urandom;
        return $signed(16'($urandom_range(2 * span))) - 16'(span);
    endfunction

    task automatic push_tri(logic signed [15:0] ax, ay, bx, by_coord, cx, cy);
        tri_t t;
        t.ax = ax; t.ay = ay; t.bx = bx; t.by_coord = by_coord; t.cx = cx; t.cy = cy;
        t.node_a = $urandom;
        t.node_b = $urandom;
        t.node_c = $urandom;
        t.fin = $urandom_range(1);
        pending_tris.push_back(t);
    endtask

    // input handshake as seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= s_tvalid && s_tready;
    end

    // driver
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || in_taken)
        begin
            if (pending_tris.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                tri_t t;
                t = pending_tris.pop_front();
                expected_mats.push_back(element_stiffness(t));
                s_tvalid <= 1'b1;
                s_tdata  <= {2'b0, t.node_c, t.node_b, t.node_a,
                             t.cy, t.cx, t.by_coord, t.bx, t.ay, t.ax};
                s_tlast  <= t.fin;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // receiver stall
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= $urandom_range(99) >= recv_stall_pct;
    end

    // monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            kmat_t e;
            kmat_t a;
            for (int i = 0; i < 6; i++)
                a.k[i] = m_tdata[32*i +: 32];
            a.na = m_tdata[192 +: 10];
            a.nb = m_tdata[202 +: 10];
            a.nc = m_tdata[212 +: 10];
            a.degen = m_tuser;
            a.fin = m_tlast;
            results_seen++;
            if (expected_mats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat at %0t", $realtime);
            end
            else
            begin
                e = expected_mats.pop_front();
                if (e.degen)
                    degen_seen++;
                for (int i = 0; i < 6; i++)
                    if (e.k[i] == 32'h7FFF_FFFF || e.k[i] == 32'h8000_0000)
                        sat_seen++;
                if (a !== e)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch at %0t", $realtime);
                        for (int i = 0; i < 6; i++)
                            $display("  k[%0d] exp %h got %h", i, e.k[i], a.k[i]);
                        $display("  nodes exp %h %h %h got %h %h %h",
                                 e.na, e.nb, e.nc, a.na, a.nb, a.nc);
                        $display("  degenerate exp %b got %b, last exp %b got %b",
                                 e.degen, a.degen, e.fin, a.fin);
                    end
                end
            end
        end
    end

    initial
    begin
        int kind;
        int span;
        logic signed [15:0] x0, y0, ux, uy, k;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        mismatches = 0;
        results_seen = 0;
        degen_seen = 0;
        sat_seen = 0;
        rst_n = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: unit triangles both orientations, extremes, degenerate, saturation
        push_tri(0, 0, 1, 0, 0, 1);
        push_tri(0, 0, 0, 1, 1, 0);
        push_tri(-32768, -32768, 32767, -32768, -32768, 32767);
        push_tri(32767, 32767, -32768, 32767, 32767, -32768);
        push_tri(-32768, 32767, 32767, -32768, 32767, 32767);
        push_tri(5, 5, 5, 5, 5, 5);
        push_tri(0, 0, 10, 10, -20, -20);
        push_tri(-32768, -32768, 32767, 32767, 0, -1);
        push_tri(0, 0, 32767, 0, 0, 1);
        push_tri(0, 0, -32768, 0, 32767, 1);
        push_tri(1, 2, 4, 6, 7, 3);
        push_tri(-1, -1, -1, 0, 0, -1);
        push_tri(100, -200, 300, 400, -500, 600);
        begin
            tri_t t;
            t = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                  10'h3FF, 10'h000, 10'h2AA, 1'b1};
            pending_tris.push_back(t);
            t = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555,
                  10'h000, 10'h3FF, 10'h155, 1'b0};
            pending_tris.push_back(t);
        end

        for (int phase = 0; phase < 4; phase++)
        begin
            wait (pending_tris.size() == 0);
            send_idle_pct  = (phase == 1 || phase == 3) ? 45 : 0;
            recv_stall_pct = (phase == 2 || phase == 3) ? 45 : 0;
            if (phase == 3)
            begin
                send_idle_pct = 27;
                recv_stall_pct = 27;
            end
            for (int n = 0; n < 375; n++)
            begin
                kind = $urandom_range(9);
                span = (kind < 3) ? 0 : ((kind < 6) ? 100 : 4000);
                if (kind == 9)
                begin
                    // collinear points give a zero area
                    x0 = rand_coord(1000); y0 = rand_coord(1000);
                    ux = rand_coord(30);   uy = rand_coord(30);
                    k = rand_coord(20);
                    push_tri(x0, y0, x0 + ux, y0 + uy, x0 + k * ux, y0 + k * uy);
                end
                else if (kind == 8)
                begin
                    // long thin sliver, pushes entries into saturation
                    x0 = rand_coord(0); y0 = rand_coord(3000);
                    push_tri(x0, y0, x0 + rand_coord(20000), y0,
                             x0 + rand_coord(20000), y0 + rand_coord(1));
                end
                else
                    push_tri(rand_coord(span), rand_coord(span), rand_coord(span),
                             rand_coord(span), rand_coord(span), rand_coord(span));
            end
        end

        wait (pending_tris.size() == 0 && !s_tvalid);
        wait (expected_mats.size() == 0);
        repeat (60) @(posedge clk);
        $display("%0d triangles checked, %0d degenerate, %0d saturated entries",
                 results_seen, degen_seen, sat_seen);
        if (mismatches == 0 && expected_mats.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("simulation failed");
        $finish;
    end

endmodule
